// File: hdl/lfo_pkg.sv
// ----------------------------------------------------------------------------
// LFO package
// Shared widths, codes, interface structs and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package lfo_pkg;

    localparam int PHASE_BITS       = 32;
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int DAC_BITS         = 12;

    localparam int FREQ_W    = 19;
    localparam int LEVEL_W   = 12;
    localparam int SHAPE_W   = 2;
    localparam int MODE_W    = 2;
    localparam int ELAPSED_W = 20;
    localparam int PROD_W    = FREQ_W + ELAPSED_W;
    localparam int WAVE_W    = 17;
    localparam int SCALE_W   = WAVE_W + LEVEL_W;
    localparam int CODE_W    = SCALE_W - 16;
    localparam int IDX_W     = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int QIDX_W    = 14 + IDX_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;

    localparam logic [FREQ_W-1:0] FREQ_STEP_MIN   = 19'd43;
    localparam logic [FREQ_W-1:0] FREQ_STEP_MAX   = 19'd429497;
    localparam logic [FREQ_W-1:0] FREQ_STEP_RESET = 19'd4295;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET    = 12'd4095;

    localparam logic [31:0] DAC_MAX = 32'((64'd1 << DAC_BITS) - 64'd1);

    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STOP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

    localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 2'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 2'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 2'd2;
    localparam logic [SHAPE_W-1:0] SHAPE_SAWTOOTH = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FREQ_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_SHAPE = 2'd2;

    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_WAVE,
        ST_SCALE,
        ST_ZERO
    } t_lfo_state;

    typedef struct packed {
        logic [FREQ_W-1:0]  freq_step;
        logic [LEVEL_W-1:0] level_code;
        logic [SHAPE_W-1:0] wave_shape;
    } t_lfo_cfg;

    typedef struct packed {
        logic load_tick;
        logic clear_phase;
        logic add_phase;
        logic eval_wave;
        logic load_out;
        logic load_zero;
    } t_lfo_cmd;

    typedef struct packed {
        logic out_free;
    } t_lfo_stat;

    typedef logic [WAVE_W-1:0] t_sine_rom [0:SINE_TABLE_DEPTH];

    function automatic logic [63:0] sq_step(input logic [63:0] term, input logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        t = (t * x) >> 30;
        return t;
    endfunction

    // Taylor series through x^13 in Q30, rounded to Q15.
    function automatic logic [WAVE_W-1:0] sine_q15(input logic [63:0] x);
        logic signed [63:0] sum;
        logic [63:0]        term;
        logic [63:0]        r;
        sum  = $signed(x);
        term = x;
        term = sq_step(term, x) / 64'd6;
        sum  = sum - $signed(term);
        term = sq_step(term, x) / 64'd20;
        sum  = sum + $signed(term);
        term = sq_step(term, x) / 64'd42;
        sum  = sum - $signed(term);
        term = sq_step(term, x) / 64'd72;
        sum  = sum + $signed(term);
        term = sq_step(term, x) / 64'd110;
        sum  = sum - $signed(term);
        term = sq_step(term, x) / 64'd156;
        sum  = sum + $signed(term);
        if (sum < 0) begin
            sum = 0;
        end
        r = ($unsigned(sum) + 64'd16384) >> 15;
        if (r > 64'd32768) begin
            r = 64'd32768;
        end
        return r[WAVE_W-1:0];
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            rom[i] = sine_q15((Q30_HALF_PI * 64'(i)) / SINE_TABLE_DEPTH);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

// File: hdl/lfo_cfg_regs.sv
// ----------------------------------------------------------------------------
// LFO configuration registers
// Holds frequency step, output level and waveform selection.
// ----------------------------------------------------------------------------
module lfo_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lfo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lfo_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output lfo_pkg::t_lfo_cfg              o_cfg
);
    import lfo_pkg::*;

    t_lfo_cfg          r_cfg;
    t_lfo_cfg          n_cfg;
    logic [FREQ_W-1:0] freq_sat;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        freq_sat = i_cfg_data[FREQ_W-1:0];
        if (freq_sat < FREQ_STEP_MIN) begin
            freq_sat = FREQ_STEP_MIN;
        end else if (freq_sat > FREQ_STEP_MAX) begin
            freq_sat = FREQ_STEP_MAX;
        end
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FREQ_STEP:  n_cfg.freq_step  = freq_sat;
                REG_LEVEL_CODE: n_cfg.level_code = i_cfg_data[LEVEL_W-1:0];
                REG_WAVE_SHAPE: n_cfg.wave_shape = i_cfg_data[SHAPE_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.freq_step  <= FREQ_STEP_RESET;
            r_cfg.level_code <= LEVEL_RESET;
            r_cfg.wave_shape <= SHAPE_SINE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: hdl/lfo_ctrl.sv
// ----------------------------------------------------------------------------
// LFO controller
// Sequences one request at a time through the datapath steps.
// ----------------------------------------------------------------------------
module lfo_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [lfo_pkg::MODE_W-1:0] i_mode,
    input  lfo_pkg::t_lfo_stat         i_stat,
    output logic                       o_in_stall,
    output lfo_pkg::t_lfo_cmd          o_cmd
);
    import lfo_pkg::*;

    t_lfo_state r_state;
    t_lfo_state n_state;

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_mode)
                        MODE_TICK: begin
                            o_cmd.load_tick = 1'b1;
                            n_state         = ST_ADD;
                        end
                        MODE_STOP: begin
                            if (i_stat.out_free) begin
                                o_cmd.load_zero = 1'b1;
                            end else begin
                                n_state = ST_ZERO;
                            end
                        end
                        MODE_RESTART: begin
                            o_cmd.clear_phase = 1'b1;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ADD: begin
                o_cmd.add_phase = 1'b1;
                n_state         = ST_WAVE;
            end
            ST_WAVE: begin
                o_cmd.eval_wave = 1'b1;
                n_state         = ST_SCALE;
            end
            ST_SCALE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_ZERO: begin
                if (i_stat.out_free) begin
                    o_cmd.load_zero = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/lfo_datapath.sv
// ----------------------------------------------------------------------------
// LFO datapath
// Phase accumulator, waveform evaluation, level scaling and output register.
// ----------------------------------------------------------------------------
module lfo_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lfo_pkg::t_lfo_cfg             i_cfg,
    input  logic [lfo_pkg::ELAPSED_W-1:0] i_elapsed_us,
    input  lfo_pkg::t_lfo_cmd             i_cmd,
    input  logic                          i_out_stall,
    output lfo_pkg::t_lfo_stat            o_stat,
    output logic                          o_out_valid,
    output logic [lfo_pkg::DAC_BITS-1:0]  o_dac_code
);
    import lfo_pkg::*;

    logic [PROD_W-1:0]     r_prod;
    logic [PHASE_BITS-1:0] r_phase;
    logic [WAVE_W-1:0]     r_wave;
    logic                  r_out_valid;
    logic [DAC_BITS-1:0]   r_dac;

    logic [15:0]           f;
    logic [1:0]            quad;
    logic [QIDX_W-1:0]     qprod;
    logic [IDX_W-1:0]      idx;
    logic [WAVE_W-1:0]     sine_t;
    logic [WAVE_W-1:0]     n_wave;
    logic [SCALE_W-1:0]    scaled;
    logic [CODE_W-1:0]     code;
    logic [DAC_BITS-1:0]   n_dac;

    assign f     = r_phase[PHASE_BITS-1 -: 16];
    assign quad  = f[15:14];
    assign qprod = QIDX_W'(f[13:0]) * QIDX_W'(SINE_TABLE_DEPTH);

    always_comb begin
        idx = qprod[QIDX_W-1:14];
        if (quad[0]) begin
            idx = IDX_W'(SINE_TABLE_DEPTH) - idx;
        end
        sine_t = SINE_ROM[idx];
    end

    always_comb begin
        case (i_cfg.wave_shape)
            SHAPE_SINE: begin
                n_wave = quad[1] ? 17'd32768 - sine_t : 17'd32768 + sine_t;
            end
            SHAPE_TRIANGLE: begin
                n_wave = f[15] ? WAVE_W'(18'd131072 - {1'b0, f, 1'b0}) : {f, 1'b0};
            end
            SHAPE_SQUARE: begin
                n_wave = f[15] ? 17'd0 : 17'd65536;
            end
            default: begin
                n_wave = {1'b0, f};
            end
        endcase
    end

    always_comb begin
        scaled = SCALE_W'(r_wave) * SCALE_W'(i_cfg.level_code);
        code   = scaled[SCALE_W-1:16];
        if (32'(code) > DAC_MAX) begin
            n_dac = DAC_BITS'(DAC_MAX);
        end else begin
            n_dac = DAC_BITS'(code);
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_dac_code      = r_dac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_phase) begin
                r_phase <= '0;
            end else if (i_cmd.add_phase) begin
                r_phase <= r_phase + PHASE_BITS'(r_prod);
            end
            if (i_cmd.load_out || i_cmd.load_zero) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_tick) begin
            r_prod <= PROD_W'(i_cfg.freq_step) * PROD_W'(i_elapsed_us);
        end
        if (i_cmd.eval_wave) begin
            r_wave <= n_wave;
        end
        if (i_cmd.load_zero) begin
            r_dac <= '0;
        end else if (i_cmd.load_out) begin
            r_dac <= n_dac;
        end
    end

endmodule

// File: hdl/lfo_waveform_generator.sv
// ----------------------------------------------------------------------------
// Steps: a tick request passes through multiply, phase add, waveform and scale
// (r_prod, r_phase, r_wave, r_dac), one request at a time, with the input
// stalled until done; scale waits on output stall. A stop request loads a zero
// code into the output register, or waits in ST_ZERO until the output is free.
// Reset: synchronous, active low; phase, out valid cleared, config to defaults.
// ----------------------------------------------------------------------------
// LFO waveform generator
// Phase-accumulator oscillator with sine, triangle, square and sawtooth output.
// ----------------------------------------------------------------------------
module lfo_waveform_generator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lfo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lfo_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [lfo_pkg::MODE_W-1:0]     i_mode,
    input  logic [lfo_pkg::ELAPSED_W-1:0]  i_elapsed_us,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [lfo_pkg::DAC_BITS-1:0]   o_dac_code
);
    import lfo_pkg::*;

    t_lfo_cfg  cfg;
    t_lfo_cmd  cmd;
    t_lfo_stat stat;

    lfo_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lfo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    lfo_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_elapsed_us (i_elapsed_us),
        .i_cmd        (cmd),
        .i_out_stall  (i_out_stall),
        .o_stat       (stat),
        .o_out_valid  (o_out_valid),
        .o_dac_code   (o_dac_code)
    );

endmodule
